// ===== src/ifac_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Indexed frame to ASCII cells: shared package
// Sizes, register and mode codes, arithmetic constants, controller command
// and status types, and the glyph selection function.
// ----------------------------------------------------------------------------
package ifac_pkg;

  localparam int SRC_WIDTH       = 320;
  localparam int SRC_HEIGHT      = 200;
  localparam int PALETTE_ENTRIES = 256;

  localparam int COL_W  = 9;
  localparam int ROW_W  = 8;
  localparam int CH_W   = 8;
  localparam int RGB_W  = 3 * CH_W;
  localparam int SUM_W  = 24;
  localparam int CNT_W  = 16;
  localparam int ACC_W  = 3 * SUM_W + CNT_W;
  localparam int GLYPH_W = 7;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [1:0] REG_GRID_COLS  = 2'd0;
  localparam logic [1:0] REG_GRID_ROWS  = 2'd1;
  localparam logic [1:0] REG_COLOR_MODE = 2'd2;

  localparam logic [2:0] MODE_NONE   = 3'd0;
  localparam logic [2:0] MODE_EIGHT  = 3'd1;
  localparam logic [2:0] MODE_256    = 3'd2;
  localparam logic [2:0] MODE_TRUE   = 3'd3;
  localparam logic [2:0] MODE_SIXEL  = 3'd4;

  localparam logic REQ_PALETTE = 1'b0;
  localparam logic REQ_PIXEL   = 1'b1;

  localparam logic [8:0] WIDTH_RESET  = 9'd160;
  localparam logic [7:0] HEIGHT_RESET = 8'd50;

  localparam int DIV_STEPS  = SUM_W;
  localparam int FIN_CYCLES = 6;

  localparam int BOOST_MUL   = 13;
  localparam int BOOST_ADD   = 15;
  localparam int DIV10_RECIP = 6554;
  localparam int DIV10_SHIFT = 16;
  localparam int LUMA_R      = 2126;
  localparam int LUMA_G      = 7152;
  localparam int LUMA_B      = 722;
  localparam int LUMA_RECIP  = 1717987;
  localparam int LUMA_SHIFT  = 34;
  localparam int LIFT_ADD    = 60;
  localparam int LIFT_MUL    = 15;
  localparam int MONO_THRESHOLD = 128;
  localparam int RAMP_LAST   = 9;
  localparam int RAMP_SCALE  = 255;
  localparam int CH_MAX      = 255;

  localparam logic [6:0] GLYPH_HASH = 7'h23;
  localparam logic [6:0] GLYPH_DOT  = 7'h2E;
  localparam logic [6:0] GLYPH_RAMP [10] = '{7'h20, 7'h2E, 7'h3A, 7'h2D, 7'h3D,
                                             7'h2B, 7'h2A, 7'h23, 7'h25, 7'h40};

  typedef struct packed {
    logic pal_we;
    logic pix_capture;
    logic acc_upd;
    logic div_load;
    logic div_step;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic emit;
    logic out_free;
  } ctrl_stat_t;

  function automatic logic [GLYPH_W-1:0] glyph_of(input logic [CH_W-1:0] y,
                                                  input logic [2:0] mode);
    logic [11:0] y9;
    logic [3:0]  k;
    y9 = 12'(y) * 12'd9;
    k  = 4'd0;
    for (int i = 1; i <= RAMP_LAST; i++) begin
      if (y9 >= 12'(RAMP_SCALE * i)) k = k + 4'd1;
    end
    if (mode == MODE_NONE) begin
      glyph_of = (y > 8'(MONO_THRESHOLD)) ? GLYPH_HASH : GLYPH_DOT;
    end else begin
      glyph_of = GLYPH_RAMP[k];
    end
  endfunction

endpackage
`default_nettype wire

// ===== src/ifac_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Indexed frame to ASCII cells: channel interfaces
// Valid/ready channels for request items and for cell results.
// ----------------------------------------------------------------------------
interface ifac_in_if
  import ifac_pkg::*;
  ();
  logic            valid;
  logic            ready;
  logic            req_type;
  logic [CH_W-1:0] color_index;
  logic [CH_W-1:0] palette_red;
  logic [CH_W-1:0] palette_green;
  logic [CH_W-1:0] palette_blue;

  modport source(output valid, req_type, color_index, palette_red, palette_green,
                 palette_blue, input ready);
  modport sink(input valid, req_type, color_index, palette_red, palette_green,
               palette_blue, output ready);
endinterface

interface ifac_out_if
  import ifac_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [COL_W-1:0]   cell_col;
  logic [ROW_W-1:0]   cell_row;
  logic [GLYPH_W-1:0] glyph;
  logic [CH_W-1:0]    cell_red;
  logic [CH_W-1:0]    cell_green;
  logic [CH_W-1:0]    cell_blue;

  modport source(output valid, cell_col, cell_row, glyph, cell_red, cell_green,
                 cell_blue, input ready);
  modport sink(input valid, cell_col, cell_row, glyph, cell_red, cell_green,
               cell_blue, output ready);
endinterface
`default_nettype wire

// ===== src/indexed_frame_to_ascii_cells_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Indexed frame to ASCII cells: top level
// Downscales a 320x200 indexed frame into averaged ASCII art cells.
//
//   Channel  Direction  Handshake      Carries
//   in_ch    sink       valid/ready    palette write or next raster pixel
//   out_ch   source     valid/ready    cell position, glyph and colour
//   APB      slave      psel/penable   grid size and colour mode registers
//
// A palette write leaves the controller idle. A pixel that ends no cell passes
// palette read and accumulation; one that ends a cell also passes the shared
// divider, one quotient bit a cycle over 24 bits, six finishing stages and any
// output stall. A result waits in the output register while the next item is taken.
// Reset returns registers to 160x50 truecolor and the frame to its origin.
// ----------------------------------------------------------------------------
module indexed_frame_to_ascii_cells_top
  import ifac_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  ifac_in_if.sink                 in_ch,
  ifac_out_if.source              out_ch,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

  logic [COL_W-1:0] grid_cols;
  logic [ROW_W-1:0] grid_rows;
  logic [2:0]       color_mode;
  logic             restart;
  ctrl_cmd_t        cmd;
  ctrl_stat_t       stat;
  logic             in_ready;

  assign in_ch.ready = in_ready;

  ifac_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .grid_cols (grid_cols),
    .grid_rows (grid_rows),
    .color_mode(color_mode),
    .restart   (restart)
  );

  ifac_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_ch.valid),
    .req_type(in_ch.req_type),
    .stat    (stat),
    .in_ready(in_ready),
    .cmd     (cmd)
  );

  ifac_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .color_index  (in_ch.color_index),
    .palette_red  (in_ch.palette_red),
    .palette_green(in_ch.palette_green),
    .palette_blue (in_ch.palette_blue),
    .grid_cols    (grid_cols),
    .grid_rows    (grid_rows),
    .color_mode   (color_mode),
    .restart      (restart),
    .cmd          (cmd),
    .stat         (stat),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .out_col      (out_ch.cell_col),
    .out_row      (out_ch.cell_row),
    .out_glyph    (out_ch.glyph),
    .out_red      (out_ch.cell_red),
    .out_green    (out_ch.cell_green),
    .out_blue     (out_ch.cell_blue)
  );

endmodule
`default_nettype wire

// ===== src/ifac_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Indexed frame to ASCII cells: generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ifac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/ifac_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Indexed frame to ASCII cells: configuration registers
// APB register file for cell grid size and colour mode.
// ----------------------------------------------------------------------------
module ifac_cfg
  import ifac_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output logic      [COL_W-1:0]   grid_cols,
  output logic      [ROW_W-1:0]   grid_rows,
  output logic      [2:0]         color_mode,
  output logic                    restart
);

  logic       wr;
  logic [1:0] idx;

  assign pready  = 1'b1;
  assign idx     = paddr[3:2];
  assign wr      = psel && penable && pwrite;
  assign restart = wr && (idx == REG_GRID_COLS || idx == REG_GRID_ROWS);

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_cols  <= WIDTH_RESET;
      grid_rows  <= HEIGHT_RESET;
      color_mode <= MODE_TRUE;
    end else if (wr) begin
      case (idx)
        REG_GRID_COLS:  grid_cols  <= pwdata[COL_W-1:0];
        REG_GRID_ROWS:  grid_rows  <= pwdata[ROW_W-1:0];
        REG_COLOR_MODE: color_mode <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_GRID_COLS:  prdata = PDATA_W'(grid_cols);
      REG_GRID_ROWS:  prdata = PDATA_W'(grid_rows);
      REG_COLOR_MODE: prdata = PDATA_W'(color_mode);
      default:        prdata = '0;
    endcase
  end

  logic unused_addr;
  assign unused_addr = ^paddr[1:0];

endmodule
`default_nettype wire

// ===== src/ifac_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Indexed frame to ASCII cells: controller
// Sequences palette access, accumulation, division, finishing and output.
// ----------------------------------------------------------------------------
module ifac_ctrl
  import ifac_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic       req_type,
  input  wire ctrl_stat_t stat,
  output logic            in_ready,
  output ctrl_cmd_t       cmd
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PAL  = 6'b000010,
    S_ACC  = 6'b000100,
    S_DIV  = 6'b001000,
    S_FIN  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t     state, state_next;
  logic [4:0] cnt, cnt_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (req_type == REQ_PALETTE) cmd.pal_we = 1'b1;
          else state_next = S_PAL;
        end
      end
      S_PAL: begin
        cmd.pix_capture = 1'b1;
        state_next      = S_ACC;
      end
      S_ACC: begin
        cmd.acc_upd = 1'b1;
        if (stat.emit) begin
          cmd.div_load = 1'b1;
          cnt_next     = '0;
          state_next   = S_DIV;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 5'd1;
        if (cnt == 5'(DIV_STEPS - 1)) begin
          cnt_next   = '0;
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cnt_next = cnt + 5'd1;
        if (cnt == 5'(FIN_CYCLES - 1)) begin
          cnt_next   = '0;
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== src/ifac_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Indexed frame to ASCII cells: datapath
// Palette and column sum memories, position tracking, shared three-lane
// divider, colour and luma finishing chain and the output register.
// ----------------------------------------------------------------------------
module ifac_dp
  import ifac_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [CH_W-1:0]    color_index,
  input  wire logic [CH_W-1:0]    palette_red,
  input  wire logic [CH_W-1:0]    palette_green,
  input  wire logic [CH_W-1:0]    palette_blue,
  input  wire logic [COL_W-1:0]   grid_cols,
  input  wire logic [ROW_W-1:0]   grid_rows,
  input  wire logic [2:0]         color_mode,
  input  wire logic               restart,
  input  wire ctrl_cmd_t          cmd,
  output ctrl_stat_t              stat,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output logic      [COL_W-1:0]   out_col,
  output logic      [ROW_W-1:0]   out_row,
  output logic      [GLYPH_W-1:0] out_glyph,
  output logic      [CH_W-1:0]    out_red,
  output logic      [CH_W-1:0]    out_green,
  output logic      [CH_W-1:0]    out_blue
);

  logic [RGB_W-1:0] pal_rdata;
  logic [ACC_W-1:0] acc_rdata, acc_wdata;

  logic [COL_W-1:0] src_col, cur_col, res_col;
  logic [ROW_W-1:0] src_row, cur_row, res_row;
  logic             first_col, first_row;
  logic             last_col, last_row;
  logic [RGB_W-1:0] pix;

  logic [COL_W-1:0] wu;
  logic [ROW_W-1:0] hu;
  logic [18:0]      col_lhs, col_rhs;
  logic [16:0]      row_lhs, row_rhs;

  logic [SUM_W-1:0] old_sum [3];
  logic [SUM_W-1:0] new_sum [3];
  logic [CNT_W-1:0] old_cnt, new_cnt;
  logic             first;

  logic [SUM_W-1:0] quot [3];
  logic [CNT_W-1:0] rem [3];
  logic [CNT_W-1:0] div_n;

  logic [11:0]      v13 [3];
  logic [CH_W-1:0]  q8 [3];
  logic [CH_W-1:0]  comp [3];
  logic [21:0]      lsum;
  logic [CH_W-1:0]  y0;
  logic [12:0]      lift;
  logic             y0_zero;
  logic [CH_W-1:0]  y;
  logic             boost;

  ifac_ram #(.WIDTH(RGB_W), .DEPTH(PALETTE_ENTRIES)) u_pal_ram (
    .clk  (clk),
    .we   (cmd.pal_we),
    .waddr(color_index),
    .wdata({palette_red, palette_green, palette_blue}),
    .raddr(color_index),
    .rdata(pal_rdata)
  );

  ifac_ram #(.WIDTH(ACC_W), .DEPTH(SRC_WIDTH)) u_acc_ram (
    .clk  (clk),
    .we   (cmd.acc_upd),
    .waddr(cur_col),
    .wdata(acc_wdata),
    .raddr(cur_col),
    .rdata(acc_rdata)
  );

  always_comb begin
    if (grid_cols == '0) wu = COL_W'(1);
    else if (grid_cols > COL_W'(SRC_WIDTH)) wu = COL_W'(SRC_WIDTH);
    else wu = grid_cols;
    if (grid_rows == '0) hu = ROW_W'(1);
    else if (grid_rows > ROW_W'(SRC_HEIGHT)) hu = ROW_W'(SRC_HEIGHT);
    else hu = grid_rows;
    col_lhs = (19'(src_col) + 19'd2) * 19'(wu);
    col_rhs = (19'(cur_col) + 19'd1) * 19'(SRC_WIDTH);
    row_lhs = (17'(src_row) + 17'd2) * 17'(hu);
    row_rhs = (17'(cur_row) + 17'd1) * 17'(SRC_HEIGHT);
  end

  always_ff @(posedge clk) begin
    if (cmd.pix_capture) begin
      pix      <= pal_rdata;
      last_col <= col_lhs > col_rhs;
      last_row <= row_lhs > row_rhs;
    end
  end

  always_comb begin
    first   = first_col && first_row;
    old_cnt = acc_rdata[CNT_W-1:0];
    for (int i = 0; i < 3; i++) begin
      old_sum[i] = acc_rdata[ACC_W-1-i*SUM_W -: SUM_W];
      new_sum[i] = (first ? '0 : old_sum[i])
                   + SUM_W'(pix[RGB_W-1-i*CH_W -: CH_W]);
    end
    new_cnt   = first ? CNT_W'(1) : old_cnt + CNT_W'(1);
    acc_wdata = {new_sum[0], new_sum[1], new_sum[2], new_cnt};
  end

  assign stat.emit     = last_col && last_row;
  assign stat.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      src_col   <= '0;
      src_row   <= '0;
      cur_col   <= '0;
      cur_row   <= '0;
      first_col <= 1'b1;
      first_row <= 1'b1;
    end else if (cmd.acc_upd) begin
      if (src_col == COL_W'(SRC_WIDTH - 1)) begin
        src_col   <= '0;
        cur_col   <= '0;
        first_col <= 1'b1;
        if (src_row == ROW_W'(SRC_HEIGHT - 1)) begin
          src_row   <= '0;
          cur_row   <= '0;
          first_row <= 1'b1;
        end else begin
          src_row   <= src_row + ROW_W'(1);
          first_row <= last_row;
          if (last_row) cur_row <= cur_row + ROW_W'(1);
        end
      end else begin
        src_col   <= src_col + COL_W'(1);
        first_col <= last_col;
        if (last_col) cur_col <= cur_col + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_upd) begin
      res_col <= cur_col;
      res_row <= cur_row;
    end
  end

  always_ff @(posedge clk) begin
    logic [CNT_W:0] trial;
    if (cmd.div_load) begin
      div_n <= new_cnt;
      for (int i = 0; i < 3; i++) begin
        quot[i] <= new_sum[i];
        rem[i]  <= '0;
      end
    end else if (cmd.div_step) begin
      for (int i = 0; i < 3; i++) begin
        trial = {rem[i], quot[i][SUM_W-1]};
        if (trial >= {1'b0, div_n}) begin
          rem[i]  <= CNT_W'(trial - {1'b0, div_n});
          quot[i] <= {quot[i][SUM_W-2:0], 1'b1};
        end else begin
          rem[i]  <= trial[CNT_W-1:0];
          quot[i] <= {quot[i][SUM_W-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    boost = color_mode inside {MODE_EIGHT, MODE_256, MODE_SIXEL};
  end

  always_ff @(posedge clk) begin
    logic [24:0] bprod;
    logic [9:0]  bval;
    logic [42:0] lprod;
    logic [25:0] yprod;
    logic [9:0]  yval;
    for (int i = 0; i < 3; i++) begin
      q8[i]  <= quot[i][CH_W-1:0];
      v13[i] <= 12'(quot[i][CH_W-1:0]) * 12'(BOOST_MUL);
    end
    for (int i = 0; i < 3; i++) begin
      bprod = 25'(v13[i]) * 25'(DIV10_RECIP);
      bval  = 10'(bprod >> DIV10_SHIFT) + 10'(BOOST_ADD);
      if (!boost) comp[i] <= q8[i];
      else if (bval > 10'(CH_MAX)) comp[i] <= CH_W'(CH_MAX);
      else comp[i] <= bval[CH_W-1:0];
    end
    lsum    <= 22'(comp[0]) * 22'(LUMA_R) + 22'(comp[1]) * 22'(LUMA_G)
               + 22'(comp[2]) * 22'(LUMA_B);
    lprod   = 43'(lsum) * 43'(LUMA_RECIP);
    y0      <= CH_W'(lprod >> LUMA_SHIFT);
    lift    <= (13'(y0) + 13'(LIFT_ADD)) * 13'(LIFT_MUL);
    y0_zero <= (y0 == '0);
    yprod   = 26'(lift) * 26'(DIV10_RECIP);
    yval    = 10'(yprod >> DIV10_SHIFT);
    if (y0_zero) y <= '0;
    else if (yval > 10'(CH_MAX)) y <= CH_W'(CH_MAX);
    else y <= yval[CH_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_col   <= res_col;
      out_row   <= res_row;
      out_glyph <= glyph_of(y, color_mode);
      out_red   <= comp[0];
      out_green <= comp[1];
      out_blue  <= comp[2];
    end
  end

  logic unused_rem;
  assign unused_rem = ^{rem[0], rem[1], rem[2]};

endmodule
`default_nettype wire

// ===== src/ifac_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Indexed frame to ASCII cells: port checker
// Checks request sequencing and result holding as seen on the top ports.
// ----------------------------------------------------------------------------
module ifac_checker
  import ifac_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               in_req_type,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [COL_W-1:0]   cell_col,
  input wire logic [ROW_W-1:0]   cell_row,
  input wire logic [GLYPH_W-1:0] glyph,
  input wire logic [CH_W-1:0]    cell_red,
  input wire logic [CH_W-1:0]    cell_green,
  input wire logic [CH_W-1:0]    cell_blue
);

  // A pixel transfer keeps the block busy for at least the next cycle.
  a_pixel_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_req_type == REQ_PIXEL |=> !in_ready)
    else $error("input ready straight after a pixel transfer");

  // After a palette write the input is ready again in the next cycle.
  a_palette_quick: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_req_type == REQ_PALETTE |=> in_ready)
    else $error("input not ready after a palette write");

  // No result can appear in the cycle after any input transfer.
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared too soon after an input transfer");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cell_col) && $stable(cell_row)
      && $stable(glyph) && $stable(cell_red) && $stable(cell_green)
      && $stable(cell_blue))
    else $error("stalled result changed or dropped");

endmodule

bind indexed_frame_to_ascii_cells_top ifac_checker u_ifac_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_req_type(in_ch.req_type),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .cell_col   (out_ch.cell_col),
  .cell_row   (out_ch.cell_row),
  .glyph      (out_ch.glyph),
  .cell_red   (out_ch.cell_red),
  .cell_green (out_ch.cell_green),
  .cell_blue  (out_ch.cell_blue)
);
`default_nettype wire
